FILE: design/srb_pkg.sv
// srb_pkg: shared constants and types for the sequence reorder buffer
// no dependencies

package srb_pkg;

  localparam int SEQ_W  = 6;
  localparam int HDR_W  = 8;
  localparam int TAG_W  = 16;
  localparam int TIME_W = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd100;

  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] ST_IDLE   = 2'd0;
  localparam logic [STATE_W-1:0] ST_CHECK  = 2'd1;
  localparam logic [STATE_W-1:0] ST_SEARCH = 2'd2;
  localparam logic [STATE_W-1:0] ST_DRAIN  = 2'd3;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_FLUSH   = 1'b1;

  typedef struct packed {
    logic load;
    logic fin;
  } out_ctl_t;

endpackage

FILE: design/srb_entry_ram.sv
// srb_entry_ram: slot entry store, one write port, one registered read port
// no dependencies

module srb_entry_ram #(
  parameter int ADDR_BITS = 6,
  parameter int DATA_BITS = 24
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/srb_ctrl.sv
// srb_ctrl: sequencer with slot valid bits, expected number, timer and
// the one-slot-a-cycle forward search; depends on srb_pkg

module srb_ctrl #(
  parameter int SEQ_BITS = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             kind,
  input  logic [SEQ_BITS-1:0]              seq,
  input  logic [srb_pkg::TIME_W-1:0]       now_ms,
  input  logic [srb_pkg::TIME_W-1:0]       timeout,
  output logic                             busy,
  output logic                             wr_en,
  output logic                             rd_en,
  output logic [SEQ_BITS-1:0]              rd_addr,
  output logic [SEQ_BITS-1:0]              rel_seq,
  output srb_pkg::out_ctl_t                ctl
);

  localparam int SLOTS = 1 << SEQ_BITS;

  logic [srb_pkg::STATE_W-1:0] state;
  logic [SLOTS-1:0]            slot_valid;
  logic [SEQ_BITS:0]           count;
  logic [SEQ_BITS-1:0]         expected_seq;
  logic [SEQ_BITS-1:0]         ptr;
  logic                        timer_running;
  logic [srb_pkg::TIME_W-1:0]  missing_since;
  logic [srb_pkg::TIME_W-1:0]  now_q;
  logic                        rd_valid;
  logic [srb_pkg::TIME_W-1:0]  elapsed;
  logic                        accept;
  logic                        release_now;

  assign busy        = (state != srb_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign wr_en       = accept && (kind == srb_pkg::KIND_ARRIVAL);
  assign release_now = (state == srb_pkg::ST_CHECK) && slot_valid[expected_seq];
  assign rd_en       = release_now;
  assign rd_addr     = expected_seq;
  assign elapsed     = now_q - missing_since;
  assign ctl.load    = rd_valid;
  assign ctl.fin     = (state == srb_pkg::ST_DRAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= srb_pkg::ST_IDLE;
      slot_valid    <= '0;
      count         <= '0;
      expected_seq  <= '0;
      timer_running <= 1'b0;
      missing_since <= '0;
      rd_valid      <= 1'b0;
    end else begin
      rd_valid <= 1'b0;
      case (state)
        srb_pkg::ST_IDLE: begin
          if (accept) begin
            if (kind == srb_pkg::KIND_FLUSH) begin
              slot_valid <= '0;
              count      <= '0;
            end else begin
              slot_valid[seq] <= 1'b1;
              if (!slot_valid[seq]) begin
                count <= count + {{SEQ_BITS{1'b0}}, 1'b1};
              end
              now_q <= now_ms;
              state <= srb_pkg::ST_CHECK;
            end
          end
        end
        srb_pkg::ST_CHECK: begin
          if (slot_valid[expected_seq]) begin
            slot_valid[expected_seq] <= 1'b0;
            count         <= count - {{SEQ_BITS{1'b0}}, 1'b1};
            rel_seq       <= expected_seq;
            rd_valid      <= 1'b1;
            expected_seq  <= expected_seq + SEQ_BITS'(1);
            timer_running <= 1'b0;
          end else if (count == '0) begin
            timer_running <= 1'b0;
            state         <= srb_pkg::ST_DRAIN;
          end else if (!timer_running) begin
            missing_since <= now_q;
            timer_running <= 1'b1;
            state         <= srb_pkg::ST_DRAIN;
          end else if (elapsed < timeout) begin
            state <= srb_pkg::ST_DRAIN;
          end else begin
            ptr   <= expected_seq + SEQ_BITS'(1);
            state <= srb_pkg::ST_SEARCH;
          end
        end
        srb_pkg::ST_SEARCH: begin
          if (slot_valid[ptr]) begin
            expected_seq  <= ptr;
            timer_running <= 1'b0;
            state         <= srb_pkg::ST_CHECK;
          end else if ((ptr + SEQ_BITS'(1)) == expected_seq) begin
            state <= srb_pkg::ST_DRAIN;
          end else begin
            ptr <= ptr + SEQ_BITS'(1);
          end
        end
        srb_pkg::ST_DRAIN: begin
          state <= srb_pkg::ST_IDLE;
        end
        default: begin
          state <= srb_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/srb_out_stage.sv
// srb_out_stage: holds one released packet back so that last can be set
// on the final one, then drives the result strobe; depends on srb_pkg

module srb_out_stage #(
  parameter int SEQ_BITS = 6,
  parameter int TAG_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  srb_pkg::out_ctl_t              ctl,
  input  logic [SEQ_BITS-1:0]            rel_seq,
  input  logic [srb_pkg::HDR_W+TAG_BITS-1:0] rd_data,
  output logic                           valid,
  output logic [srb_pkg::SEQ_W-1:0]      out_seq,
  output logic [srb_pkg::HDR_W-1:0]      out_header,
  output logic [srb_pkg::TAG_W-1:0]      out_tag,
  output logic                           last
);

  logic                                pend_valid;
  logic [SEQ_BITS-1:0]                 pend_seq;
  logic [srb_pkg::HDR_W+TAG_BITS-1:0]  pend_entry;
  logic                                emit;

  assign emit = pend_valid && (ctl.load || ctl.fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      valid <= emit;
      if (ctl.load) begin
        pend_valid <= 1'b1;
      end else if (ctl.fin) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_seq    <= srb_pkg::SEQ_W'(pend_seq);
      out_header <= pend_entry[TAG_BITS +: srb_pkg::HDR_W];
      out_tag    <= srb_pkg::TAG_W'(pend_entry[TAG_BITS-1:0]);
      last       <= !ctl.load;
    end
    if (ctl.load) begin
      pend_seq   <= rel_seq;
      pend_entry <= rd_data;
    end
  end

endmodule

FILE: design/sequence_reorder_buffer.sv
// sequence_reorder_buffer: resequencer for numbered packets with timeout skip
// top level; depends on srb_pkg, srb_entry_ram, srb_ctrl, srb_out_stage
// an arrival keeps busy high after its transfer while it releases packets and, when it
// skips ahead d slots (d at most 2^SEQ_BITS - 1), while it searches; a flush never sets busy
// results leave one per cycle, each held back until the next release or the end of its item; the receiver cannot stall
// synchronous reset clears all valid bits, expected number and timer; timeout 100

module sequence_reorder_buffer #(
  parameter int SEQ_BITS = 6,
  parameter int TAG_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [srb_pkg::SEQ_W-1:0]     seq_num,
  input  logic [srb_pkg::HDR_W-1:0]     header,
  input  logic [srb_pkg::TAG_W-1:0]     packet_tag,
  input  logic [srb_pkg::TIME_W-1:0]    now_ms,
  input  logic                          cfg_we,
  input  logic [srb_pkg::TIME_W-1:0]    cfg_wdata,
  output logic                          valid,
  output logic [srb_pkg::SEQ_W-1:0]     out_seq,
  output logic [srb_pkg::HDR_W-1:0]     out_header,
  output logic [srb_pkg::TAG_W-1:0]     out_tag,
  output logic                          last
);

  localparam int ENTRY_BITS = srb_pkg::HDR_W + TAG_BITS;

  logic [srb_pkg::TIME_W-1:0] missing_timeout_ms;
  logic [SEQ_BITS-1:0]        seq;
  logic [ENTRY_BITS-1:0]      wr_data;
  logic [ENTRY_BITS-1:0]      rd_data;
  logic                       wr_en;
  logic                       rd_en;
  logic [SEQ_BITS-1:0]        rd_addr;
  logic [SEQ_BITS-1:0]        rel_seq;
  srb_pkg::out_ctl_t          ctl;

  assign seq     = seq_num[SEQ_BITS-1:0];
  assign wr_data = {header, TAG_BITS'(packet_tag)};

  always_ff @(posedge clk) begin
    if (rst) begin
      missing_timeout_ms <= srb_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      missing_timeout_ms <= cfg_wdata;
    end
  end

  srb_ctrl #(
    .SEQ_BITS(SEQ_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .kind    (kind),
    .seq     (seq),
    .now_ms  (now_ms),
    .timeout (missing_timeout_ms),
    .busy    (busy),
    .wr_en   (wr_en),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rel_seq (rel_seq),
    .ctl     (ctl)
  );

  srb_entry_ram #(
    .ADDR_BITS(SEQ_BITS),
    .DATA_BITS(ENTRY_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (seq),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srb_out_stage #(
    .SEQ_BITS(SEQ_BITS),
    .TAG_BITS(TAG_BITS)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rel_seq    (rel_seq),
    .rd_data    (rd_data),
    .valid      (valid),
    .out_seq    (out_seq),
    .out_header (out_header),
    .out_tag    (out_tag),
    .last       (last)
  );

  // a result transfer only follows a new release or the end of an item
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(ctl.load || ctl.fin))
    else $error("result strobe without release");

  // a flush never occupies the block
  a_flush_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == srb_pkg::KIND_FLUSH) |=> !busy)
    else $error("flush left block busy");

  // an arrival always occupies the block in the cycle after it is taken
  a_arrival_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == srb_pkg::KIND_ARRIVAL) |=> busy)
    else $error("arrival not taken up");

endmodule
